FILE: rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared widths, constants and types of the barometric compensation core.
// ----------------------------------------------------------------------------
package bpt_pkg;

	localparam int RAW_W      = 24;
	localparam int CAL_W      = 16;
	localparam int DT_W       = 25;
	localparam int PROD_W     = 42;
	localparam int TEMP1_W    = 20;
	localparam int TEMP_W     = 21;
	localparam int OFF_W      = 40;
	localparam int SENS_W     = 40;
	localparam int P_W        = 31;
	localparam int TEMP_OUT_W = 15;
	localparam int PRESS_OUT_W = 17;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam int T_SHIFT    = 23;
	localparam int OFF_SHIFT  = 7;
	localparam int SENS_SHIFT = 8;
	localparam int T2_SHIFT   = 31;
	localparam int PROD_SHIFT = 21;
	localparam int P_SHIFT    = 15;

	localparam logic signed [TEMP1_W-1:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [TEMP1_W-1:0] TEMP_COLD = -20'sd1500;
	localparam logic signed [TEMP_W-1:0]  TEMP_MIN  = -21'sd4000;
	localparam logic signed [TEMP_W-1:0]  TEMP_MAX  = 21'sd8500;
	localparam logic signed [P_W-1:0]     PRESS_MIN = 31'sd1000;
	localparam logic signed [P_W-1:0]     PRESS_MAX = 31'sd120000;

	typedef enum logic [2:0] {
		REG_SENS_BASE     = 3'd0,
		REG_OFFSET_BASE   = 3'd1,
		REG_SENS_TEMPCO   = 3'd2,
		REG_OFFSET_TEMPCO = 3'd3,
		REG_REF_TEMP      = 3'd4,
		REG_TEMP_SLOPE    = 3'd5
	} bpt_reg_t;

	typedef struct packed {
		logic [CAL_W-1:0] sens_base;
		logic [CAL_W-1:0] offset_base;
		logic [CAL_W-1:0] sens_tempco;
		logic [CAL_W-1:0] offset_tempco;
		logic [CAL_W-1:0] ref_temp;
		logic [CAL_W-1:0] temp_slope;
	} bpt_cal_t;

	// first-order results and class of one word, passed from front to back
	typedef struct packed {
		logic [RAW_W-1:0]          raw_press;
		logic signed [DT_W-1:0]    dt;
		logic signed [TEMP1_W-1:0] temp1;
		logic signed [OFF_W-1:0]   off1;
		logic signed [SENS_W-1:0]  sens1;
		logic                      cool;
		logic                      cold;
	} bpt_work_t;

endpackage

FILE: rtl/core/bpt_if.sv
// ----------------------------------------------------------------------------
// bpt_if
// Valid/ready stream interfaces for raw conversions and compensated results.
// ----------------------------------------------------------------------------
interface bpt_in_if;
	import bpt_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_press;
	logic [RAW_W-1:0] raw_temp;
	modport source (output valid, raw_press, raw_temp, input ready);
	modport sink (input valid, raw_press, raw_temp, output ready);
endinterface

interface bpt_out_if;
	import bpt_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [TEMP_OUT_W-1:0] temp_centi;
	logic [PRESS_OUT_W-1:0]       press_centi;
	logic                         out_of_range;
	modport source (output valid, temp_centi, press_centi, out_of_range, input ready);
	modport sink (input valid, temp_centi, press_centi, out_of_range, output ready);
endinterface

FILE: rtl/core/baro_pressure_temp_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core
// Second-order compensation of raw barometric pressure and temperature.
// ----------------------------------------------------------------------------
// Takes one word per clock (raw 24-bit pressure and temperature) and returns
// one word per clock while the result side keeps up: temperature in 0.01 C
// and pressure in 0.01 mbar, both saturated, with a flag when either was
// clamped. A three-stage front forms dT and the first-order terms and sorts
// each word by temperature band; a queue of QUEUE_DEPTH words feeds a
// seven-stage back end that applies the second-order terms and the pressure
// multiply, split in two partial products.
// Calibration words sit in an APB register file at byte offsets 0 to 20
// and are to be written while no word is in flight.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bpt_in_if.sink                     in_ch,
	bpt_out_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bpt_pkg::ADDR_W-1:0] paddr,
	input  logic [bpt_pkg::DATA_W-1:0] pwdata,
	output logic [bpt_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import bpt_pkg::*;

	bpt_cal_t  cal;
	bpt_work_t push_word, head_word;
	logic      push, pop, q_full, head_valid;

	assign pready = 1'b1;

	bpt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cal     (cal)
	);

	bpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cal       (cal),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	bpt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word)
	);

	bpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

FILE: rtl/core/bpt_cfg.sv
// ----------------------------------------------------------------------------
// bpt_cfg
// APB register file holding the six factory calibration words.
// ----------------------------------------------------------------------------
module bpt_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bpt_pkg::ADDR_W-1:0] paddr,
	input  logic [bpt_pkg::DATA_W-1:0] pwdata,
	output logic [bpt_pkg::DATA_W-1:0] prdata,
	output bpt_pkg::bpt_cal_t         cal
);
	import bpt_pkg::*;

	bpt_cal_t cal_q;
	bpt_reg_t idx;
	logic     wr_en;

	assign idx   = bpt_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cal   = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SENS_BASE:     cal_q.sens_base     <= pwdata[CAL_W-1:0];
				REG_OFFSET_BASE:   cal_q.offset_base   <= pwdata[CAL_W-1:0];
				REG_SENS_TEMPCO:   cal_q.sens_tempco   <= pwdata[CAL_W-1:0];
				REG_OFFSET_TEMPCO: cal_q.offset_tempco <= pwdata[CAL_W-1:0];
				REG_REF_TEMP:      cal_q.ref_temp      <= pwdata[CAL_W-1:0];
				REG_TEMP_SLOPE:    cal_q.temp_slope    <= pwdata[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SENS_BASE:     prdata = DATA_W'(cal_q.sens_base);
			REG_OFFSET_BASE:   prdata = DATA_W'(cal_q.offset_base);
			REG_SENS_TEMPCO:   prdata = DATA_W'(cal_q.sens_tempco);
			REG_OFFSET_TEMPCO: prdata = DATA_W'(cal_q.offset_tempco);
			REG_REF_TEMP:      prdata = DATA_W'(cal_q.ref_temp);
			REG_TEMP_SLOPE:    prdata = DATA_W'(cal_q.temp_slope);
			default:           prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/bpt_front.sv
// ----------------------------------------------------------------------------
// bpt_front
// Accepts raw conversions, forms dT and the first-order terms, and classifies
// each word by temperature band before handing it to the queue.
// ----------------------------------------------------------------------------
module bpt_front (
	input  logic               clk,
	input  logic               arst_n,
	bpt_in_if.sink             in_ch,
	input  bpt_pkg::bpt_cal_t  cal,
	input  logic               q_full,
	output logic               push,
	output bpt_pkg::bpt_work_t push_word
);
	import bpt_pkg::*;

	logic adv;
	logic valid_s1, valid_s2, valid_s3;

	logic [RAW_W-1:0]         d1_s1, d1_s2;
	logic signed [DT_W-1:0]   dt_s1, dt_s2;
	logic signed [PROD_W-1:0] prod_t_s2, prod_off_s2, prod_sens_s2;
	bpt_work_t                word_s3;

	logic signed [PROD_W-T_SHIFT-1:0] t_adj;
	logic signed [TEMP1_W-1:0]        temp1;

	assign adv         = !(valid_s3 && q_full);
	assign in_ch.ready = adv;
	assign push        = valid_s3 && adv;
	assign push_word   = word_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_ch.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign t_adj = (PROD_W-T_SHIFT)'(prod_t_s2 >>> T_SHIFT);
	assign temp1 = TEMP_REF + TEMP1_W'(t_adj);

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1 <= in_ch.raw_press;
			dt_s1 <= $signed({1'b0, in_ch.raw_temp}) - $signed({1'b0, cal.ref_temp, 8'd0});

			d1_s2        <= d1_s1;
			dt_s2        <= dt_s1;
			prod_t_s2    <= PROD_W'(dt_s1) * PROD_W'($signed({1'b0, cal.temp_slope}));
			prod_off_s2  <= PROD_W'(dt_s1) * PROD_W'($signed({1'b0, cal.offset_tempco}));
			prod_sens_s2 <= PROD_W'(dt_s1) * PROD_W'($signed({1'b0, cal.sens_tempco}));

			word_s3.raw_press <= d1_s2;
			word_s3.dt        <= dt_s2;
			word_s3.temp1     <= temp1;
			word_s3.off1      <= OFF_W'($signed({1'b0, cal.offset_base, 16'd0}))
				+ OFF_W'(prod_off_s2 >>> OFF_SHIFT);
			word_s3.sens1     <= SENS_W'($signed({1'b0, cal.sens_base, 15'd0}))
				+ SENS_W'(prod_sens_s2 >>> SENS_SHIFT);
			// below 20 C exactly when the slope product is negative
			word_s3.cool      <= prod_t_s2[PROD_W-1];
			word_s3.cold      <= temp1 < TEMP_COLD;
		end
	end

endmodule

FILE: rtl/core/bpt_queue.sv
// ----------------------------------------------------------------------------
// bpt_queue
// Small FIFO of classified words between the front and back pipelines.
// ----------------------------------------------------------------------------
module bpt_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bpt_pkg::bpt_work_t push_word,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output bpt_pkg::bpt_work_t head_word
);
	import bpt_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bpt_work_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == FULL_CNT;
	assign head_valid = count_q != '0;
	assign head_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

FILE: rtl/core/bpt_back.sv
// ----------------------------------------------------------------------------
// bpt_back
// Applies the second-order corrections, forms pressure with a split
// multiply, saturates both results and holds them in the output register.
// ----------------------------------------------------------------------------
module bpt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  bpt_pkg::bpt_work_t head_word,
	output logic               pop,
	bpt_out_if.source          out_ch
);
	import bpt_pkg::*;

	localparam int SQ_W   = 40;
	localparam int DSQ_W  = 50;
	localparam int T2_W   = DSQ_W - T2_SHIFT;
	localparam int LO_W   = 20;
	localparam int PL_W   = RAW_W + LO_W;
	localparam int PH_W   = RAW_W + 1 + SENS_W - LO_W;
	localparam int FULL_W = 66;
	localparam int PS_W   = FULL_W - PROD_SHIFT;
	localparam int PD_W   = PS_W + 1;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, out_valid_q;

	// stage 1: squares
	logic [RAW_W-1:0]          d1_s1, d1_s2, d1_s3;
	logic signed [TEMP1_W-1:0] temp1_s1, temp1_s2;
	logic signed [OFF_W-1:0]   off1_s1, off1_s2;
	logic signed [SENS_W-1:0]  sens1_s1, sens1_s2;
	logic                      cool_s1, cool_s2, cold_s1, cold_s2;
	logic signed [SQ_W-1:0]    dd_s1, ee_s1;
	logic signed [DSQ_W-1:0]   dtsq_s1;
	logic signed [TEMP1_W-1:0] d_cur, e_cur;

	// stage 2: constant multiples
	logic signed [SQ_W-1:0]    m5_s2, m7_s2, m11_s2;
	logic signed [T2_W-1:0]    t2_s2;

	// stage 3: corrected terms
	logic signed [TEMP_W-1:0]  temp_s3;
	logic signed [OFF_W-1:0]   off_s3, off_s4, off_s5;
	logic signed [SENS_W-1:0]  sens_s3;
	logic signed [OFF_W-1:0]   off2;
	logic signed [SENS_W-1:0]  sens2;
	logic signed [T2_W-1:0]    t2_eff;

	// stage 4..6: pressure
	logic [PL_W-1:0]           pl_s4;
	logic signed [PH_W-1:0]    ph_s4;
	logic signed [FULL_W-1:0]  full_s5;
	logic signed [PS_W-1:0]    pscale;
	logic signed [PD_W-1:0]    pdiff;
	logic signed [P_W-1:0]     p_s6;
	logic signed [TEMP_W-1:0]  tclamp_s4, tclamp_s5, tclamp_s6;
	logic                      tflag_s4, tflag_s5, tflag_s6;

	logic signed [TEMP_OUT_W-1:0] temp_q;
	logic [PRESS_OUT_W-1:0]       press_q;
	logic                         flag_q;

	assign en  = !out_valid_q || out_ch.ready;
	assign pop = en && head_valid;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.temp_centi   = temp_q;
	assign out_ch.press_centi  = press_q;
	assign out_ch.out_of_range = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			out_valid_q <= valid_s6;
		end
	end

	assign d_cur = head_word.temp1 - TEMP_REF;
	assign e_cur = head_word.temp1 - TEMP_COLD;

	always_comb begin
		off2   = '0;
		sens2  = '0;
		t2_eff = '0;
		if (cool_s2) begin
			t2_eff = t2_s2;
			off2   = m5_s2 >>> 1;
			sens2  = m5_s2 >>> 2;
			if (cold_s2) begin
				off2  = off2 + m7_s2;
				sens2 = sens2 + (m11_s2 >>> 1);
			end
		end
	end

	assign pscale = PS_W'(full_s5 >>> PROD_SHIFT);
	assign pdiff  = PD_W'(pscale) - PD_W'(off_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1    <= head_word.raw_press;
			temp1_s1 <= head_word.temp1;
			off1_s1  <= head_word.off1;
			sens1_s1 <= head_word.sens1;
			cool_s1  <= head_word.cool;
			cold_s1  <= head_word.cold;
			dd_s1    <= SQ_W'(d_cur) * SQ_W'(d_cur);
			ee_s1    <= SQ_W'(e_cur) * SQ_W'(e_cur);
			dtsq_s1  <= DSQ_W'(head_word.dt) * DSQ_W'(head_word.dt);

			d1_s2    <= d1_s1;
			temp1_s2 <= temp1_s1;
			off1_s2  <= off1_s1;
			sens1_s2 <= sens1_s1;
			cool_s2  <= cool_s1;
			cold_s2  <= cold_s1;
			t2_s2    <= T2_W'(dtsq_s1 >>> T2_SHIFT);
			m5_s2    <= dd_s1 + (dd_s1 <<< 2);
			m7_s2    <= (ee_s1 <<< 3) - ee_s1;
			m11_s2   <= (ee_s1 <<< 3) + (ee_s1 <<< 1) + ee_s1;

			d1_s3   <= d1_s2;
			temp_s3 <= TEMP_W'(temp1_s2) - TEMP_W'(t2_eff);
			off_s3  <= off1_s2 - off2;
			sens_s3 <= sens1_s2 - sens2;

			// split multiply of raw pressure by sens
			pl_s4 <= PL_W'(d1_s3) * PL_W'(sens_s3[LO_W-1:0]);
			ph_s4 <= PH_W'($signed({1'b0, d1_s3})) * PH_W'($signed(sens_s3[SENS_W-1:LO_W]));
			off_s4 <= off_s3;
			if (temp_s3 < TEMP_MIN) begin
				tclamp_s4 <= TEMP_MIN;
				tflag_s4  <= 1'b1;
			end else if (temp_s3 > TEMP_MAX) begin
				tclamp_s4 <= TEMP_MAX;
				tflag_s4  <= 1'b1;
			end else begin
				tclamp_s4 <= temp_s3;
				tflag_s4  <= 1'b0;
			end

			full_s5   <= (FULL_W'(ph_s4) <<< LO_W) + $signed({(FULL_W-PL_W)'(0), pl_s4});
			off_s5    <= off_s4;
			tclamp_s5 <= tclamp_s4;
			tflag_s5  <= tflag_s4;

			p_s6      <= P_W'(pdiff >>> P_SHIFT);
			tclamp_s6 <= tclamp_s5;
			tflag_s6  <= tflag_s5;

			temp_q <= TEMP_OUT_W'(tclamp_s6);
			if (p_s6 < PRESS_MIN) begin
				press_q <= PRESS_OUT_W'(PRESS_MIN);
				flag_q  <= 1'b1;
			end else if (p_s6 > PRESS_MAX) begin
				press_q <= PRESS_OUT_W'(PRESS_MAX);
				flag_q  <= 1'b1;
			end else begin
				press_q <= PRESS_OUT_W'(p_s6);
				flag_q  <= tflag_s6;
			end
		end
	end

endmodule

FILE: bench/baro_pressure_temp_compensation_core_test.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core_test
// Self-checking bench for the barometric compensation core.
// ----------------------------------------------------------------------------
// Loads calibration sets over the register port while the core is idle, then
// streams raw pressure and temperature pairs into it. A local integer model
// computes each compensated word as it is accepted, and every result word is
// compared field by field with the oldest pending prediction. The directed
// tests cover reset calibration, register writes, the temperature bands and
// the clamp limits. A long random run follows over several calibration sets,
// and a final test stalls the result side long enough to back up the input.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core_test;
	import bpt_pkg::*;

	localparam int     LATENCY    = 11;
	localparam int     IDLE_LIMIT = 3000;
	localparam int     HOLD_LEN   = 400;
	localparam longint RAW_MAX    = 16777215;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [15:0] TYP_C1 = 16'd40127;
	localparam logic [15:0] TYP_C2 = 16'd36924;
	localparam logic [15:0] TYP_C3 = 16'd23317;
	localparam logic [15:0] TYP_C4 = 16'd23282;
	localparam logic [15:0] TYP_C5 = 16'd33464;
	localparam logic [15:0] TYP_C6 = 16'd28312;
	localparam logic [23:0] TYP_D1 = 24'd9085466;
	localparam logic [23:0] TYP_D2 = 24'd8569150;

	typedef struct packed {
		longint dt;
		longint temp;
		longint off;
		longint sens;
	} first_terms_t;

	typedef struct packed {
		logic signed [TEMP_OUT_W-1:0] temp_centi;
		logic [PRESS_OUT_W-1:0]       press_centi;
		logic                         out_of_range;
	} comp_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	bpt_in_if  in_ch();
	bpt_out_if out_ch();

	logic [CAL_W-1:0] cal_word [6];
	comp_word_t expected_words [$];
	comp_word_t due_word;
	int unsigned error_count = 0;
	int unsigned word_index = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_hold = 0;
	bit idle_on = 1'b1;

	baro_pressure_temp_compensation_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic first_terms_t first_order(input logic [RAW_W-1:0] temp_raw);
		first_terms_t ft;
		longint c1, c2, c3, c4, c5, c6, d2, dt;
		c1 = longint'(cal_word[REG_SENS_BASE]);
		c2 = longint'(cal_word[REG_OFFSET_BASE]);
		c3 = longint'(cal_word[REG_SENS_TEMPCO]);
		c4 = longint'(cal_word[REG_OFFSET_TEMPCO]);
		c5 = longint'(cal_word[REG_REF_TEMP]);
		c6 = longint'(cal_word[REG_TEMP_SLOPE]);
		d2 = longint'(temp_raw);
		dt = d2 - c5 * 256;
		ft.dt = dt;
		ft.temp = 2000 + ((dt * c6) >>> T_SHIFT);
		ft.off = c2 * 65536 + ((c4 * dt) >>> OFF_SHIFT);
		ft.sens = c1 * 32768 + ((c3 * dt) >>> SENS_SHIFT);
		return ft;
	endfunction

	function automatic comp_word_t compensate(input logic [RAW_W-1:0] press_raw,
			input logic [RAW_W-1:0] temp_raw);
		first_terms_t ft;
		comp_word_t w;
		longint d1, dt, temp, off, sens, sq, p;
		bit clamped;
		ft = first_order(temp_raw);
		d1 = longint'(press_raw);
		dt = ft.dt;
		temp = ft.temp;
		off = ft.off;
		sens = ft.sens;
		clamped = 1'b0;
		// second-order terms, band tests on the first-order temperature
		if (temp < longint'(TEMP_REF)) begin
			sq = (temp - 2000) * (temp - 2000);
			off = off - ((5 * sq) >>> 1);
			sens = sens - ((5 * sq) >>> 2);
			if (temp < longint'(TEMP_COLD)) begin
				sq = (temp + 1500) * (temp + 1500);
				off = off - 7 * sq;
				sens = sens - ((11 * sq) >>> 1);
			end
			temp = temp - ((dt * dt) >>> T2_SHIFT);
		end
		p = (((d1 * sens) >>> PROD_SHIFT) - off) >>> P_SHIFT;
		if (temp < longint'(TEMP_MIN)) begin
			temp = longint'(TEMP_MIN);
			clamped = 1'b1;
		end
		if (temp > longint'(TEMP_MAX)) begin
			temp = longint'(TEMP_MAX);
			clamped = 1'b1;
		end
		if (p < longint'(PRESS_MIN)) begin
			p = longint'(PRESS_MIN);
			clamped = 1'b1;
		end
		if (p > longint'(PRESS_MAX)) begin
			p = longint'(PRESS_MAX);
			clamped = 1'b1;
		end
		w.temp_centi = temp[TEMP_OUT_W-1:0];
		w.press_centi = p[PRESS_OUT_W-1:0];
		w.out_of_range = clamped;
		return w;
	endfunction

	// raw pair aimed at a temperature and pressure under the current calibration
	function automatic logic [47:0] target_pair(input longint t_goal, input longint p_goal);
		first_terms_t ft;
		longint dt, d1, d2, sens, off;
		if (cal_word[REG_TEMP_SLOPE] != '0)
			dt = ((t_goal - 2000) * 8388608) / longint'(cal_word[REG_TEMP_SLOPE]);
		else
			dt = longint'($urandom_range(0, 2097152)) - 1048576;
		d2 = longint'(cal_word[REG_REF_TEMP]) * 256 + dt;
		if (d2 < 0)
			d2 = 0;
		if (d2 > RAW_MAX)
			d2 = RAW_MAX;
		ft = first_order(d2[RAW_W-1:0]);
		sens = ft.sens;
		off = ft.off;
		if (sens > 0)
			d1 = ((p_goal * 32768 + off) * 2097152) / sens;
		else
			d1 = longint'($urandom_range(0, 16777215));
		if (d1 < 0)
			d1 = 0;
		if (d1 > RAW_MAX)
			d1 = RAW_MAX;
		return {d1[RAW_W-1:0], d2[RAW_W-1:0]};
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic send_pair(input logic [RAW_W-1:0] press_raw, input logic [RAW_W-1:0] temp_raw);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.raw_press <= press_raw;
		in_ch.raw_temp <= temp_raw;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
	endtask

	task automatic send_target(input longint t_goal, input longint p_goal);
		logic [47:0] pair;
		pair = target_pair(t_goal, p_goal);
		send_pair(pair[47:24], pair[23:0]);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_cal(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx <= REG_TEMP_SLOPE)
			cal_word[idx] = value[CAL_W-1:0];
		@(posedge clk);
	endtask

	task automatic load_cal(input logic [15:0] c1, input logic [15:0] c2, input logic [15:0] c3,
			input logic [15:0] c4, input logic [15:0] c5, input logic [15:0] c6);
		settle();
		write_cal(REG_SENS_BASE, {16'h0000, c1});
		write_cal(REG_OFFSET_BASE, {16'h0000, c2});
		write_cal(REG_SENS_TEMPCO, {16'h0000, c3});
		write_cal(REG_OFFSET_TEMPCO, {16'h0000, c4});
		write_cal(REG_REF_TEMP, {16'h0000, c5});
		write_cal(REG_TEMP_SLOPE, {16'h0000, c6});
	endtask

	task automatic test_reset_calibration();
		send_pair(TYP_D1, TYP_D2);
		send_pair(24'h000000, 24'h000000);
		send_pair(24'hFFFFFF, 24'hFFFFFF);
	endtask

	task automatic test_register_writes();
		settle();
		// upper half of the data bus is dropped
		write_cal(REG_SENS_BASE, {16'hA5A5, TYP_C1});
		write_cal(REG_OFFSET_BASE, {16'h5A5A, TYP_C2});
		write_cal(REG_SENS_TEMPCO, {16'hFFFF, TYP_C3});
		write_cal(REG_OFFSET_TEMPCO, {16'h8001, TYP_C4});
		write_cal(REG_REF_TEMP, {16'h7FFE, TYP_C5});
		write_cal(REG_TEMP_SLOPE, {16'hC3C3, TYP_C6});
		// spare offsets hold nothing
		write_cal(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_cal(REG_SPARE_HI, 32'h1234_5678);
		send_pair(TYP_D1, TYP_D2);
		send_pair(24'hFFFFFF, TYP_D2);
		load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pair(24'h000000, 24'h000000);
		send_pair(24'hFFFFFF, 24'hFFFFFF);
		send_pair(24'h000000, 24'hFFFFFF);
		send_pair(24'hFFFFFF, 24'h000000);
	endtask

	task automatic test_temperature_bands();
		load_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
		send_target(2000, 100000);
		send_target(1999, 100000);
		send_target(1000, 95000);
		send_target(-1500, 90000);
		send_target(-1501, 90000);
		send_target(-3000, 80000);
		send_target(-5000, 80000);
		send_target(9500, 100000);
	endtask

	task automatic test_pressure_limits();
		send_target(2500, 500);
		send_target(2500, 130000);
		send_pair(24'h000000, TYP_D2);
		send_pair(24'hFFFFFF, TYP_D2);
	endtask

	task automatic test_random_calibrations();
		logic [47:0] pair;
		int unsigned pick;
		for (int s = 0; s < 6; s++) begin
			if (s == 0)
				load_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
			else if (s == 1)
				load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			else
				load_cal(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			repeat (300) begin
				if ($urandom_range(0, 59) == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				pair = target_pair(longint'($urandom_range(0, 16000)) - 6000,
					longint'($urandom_range(500, 125000)));
				pick = $urandom_range(0, 9);
				if (pick == 7) begin
					if ($urandom_range(0, 1) == 0)
						pair[47:24] = 24'($urandom());
					else
						pair[23:0] = 24'($urandom());
				end else if (pick >= 8) begin
					pair[47:24] = 24'($urandom());
					pair[23:0] = 24'($urandom());
				end
				send_pair(pair[47:24], pair[23:0]);
			end
		end
		idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		load_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
		idle_on = 1'b0;
		rx_hold = HOLD_LEN;
		repeat (60)
			send_target(longint'($urandom_range(0, 12000)) - 3000,
				longint'($urandom_range(1000, 120000)));
		idle_on = 1'b1;
	endtask

	// result side: random gaps, plus one long hold on request
	initial begin : result_sink
		int unsigned gap;
		out_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold != 0) begin
				gap = rx_hold;
				rx_hold = 0;
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			gap = idle_on ? $urandom_range(0, 11) : 0;
			if (gap != 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			expected_words.push_back(compensate(in_ch.raw_press, in_ch.raw_temp));
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_error("result word with none expected");
			end else begin
				due_word = expected_words.pop_front();
				if (out_ch.temp_centi !== due_word.temp_centi)
					report_error($sformatf("word %0d temp_centi: got %0d, expected %0d",
						word_index, $signed(out_ch.temp_centi),
						$signed(due_word.temp_centi)));
				if (out_ch.press_centi !== due_word.press_centi)
					report_error($sformatf("word %0d press_centi: got %0d, expected %0d",
						word_index, out_ch.press_centi, due_word.press_centi));
				if (out_ch.out_of_range !== due_word.out_of_range)
					report_error($sformatf("word %0d out_of_range: got %0b, expected %0b",
						word_index, out_ch.out_of_range, due_word.out_of_range));
			end
			word_index++;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		cal_word = '{default: '0};
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.raw_press <= '0;
		in_ch.raw_temp <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_calibration();
		test_register_writes();
		test_temperature_bands();
		test_pressure_limits();
		test_random_calibrations();
		test_output_backpressure();
		settle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
